/* rtl/core/mpc_pkg.sv */
// shared types and constants for the mandelbrot pixel colorizer
package mpc_pkg;

    // default values of the top-level parameters
    localparam int DEF_MAX_ITERATIONS = 128;
    localparam int DEF_FRACTION_BITS  = 28;

    // port widths fixed by the pixel and color formats
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;
    localparam int COORD_W   = 12;
    localparam int COLOR_W   = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;

    // configuration register reset values
    localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

    // operations of the shared iteration unit
    typedef enum logic [2:0] {
        IT_NOP,
        IT_LOAD_CR,
        IT_LOAD_CI,
        IT_SQR_R,
        IT_SQR_I,
        IT_CROSS,
        IT_UPDATE
    } it_op_t;

    // status returned by the iteration unit to the sequencer
    typedef struct packed {
        logic escape;
        logic at_limit;
    } iter_status_t;

endpackage

/* rtl/core/mpc_div.sv */
// restoring divider for the coordinate scaling, one quotient bit per cycle
module mpc_div import mpc_pkg::*; #(
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [COORD_W+1:0]         num,
    input  logic [CFG_W-1:0]           den,
    output logic                       done,
    output logic [FRACTION_BITS+4:0]   quo
);

    localparam int QW = FRACTION_BITS + 4;
    localparam int CW = $clog2(QW);
    localparam int RW = CFG_W + 4;

    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic          cap_reg, cap_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [RW-1:0] rem_reg, rem_next;
    logic [RW-2:0] dsh_reg, dsh_next;
    logic [QW-1:0] q_reg, q_next;

    logic [RW-1:0] rem_sub;
    logic          fits;

    // one restoring step against the divisor scaled by eight
    always_comb
    begin
        fits    = (rem_reg >= {1'b0, dsh_reg});
        rem_sub = fits ? (rem_reg - {1'b0, dsh_reg}) : rem_reg;
    end

    // step control
    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cap_next  = cap_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        if (start)
        begin
            run_next = 1'b1;
            cap_next = ({3'b000, num} >= {den, 4'b0000});
            cnt_next = '0;
            rem_next = {3'b000, num};
            dsh_next = {den, 3'b000};
            q_next   = '0;
        end
        else if (run_reg)
        begin
            rem_next = {rem_sub[RW-2:0], 1'b0};
            q_next   = {q_reg[QW-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(QW - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cap_reg  <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            dsh_reg  <= '0;
            q_reg    <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cap_reg  <= cap_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            dsh_reg  <= dsh_next;
            q_reg    <= q_next;
        end
    end

    // quotient capped at sixteen
    assign done = done_reg;
    assign quo  = cap_reg ? ((QW+1)'(16) << FRACTION_BITS) : {1'b0, q_reg};

endmodule

/* rtl/core/mpc_iter.sv */
// escape-time iteration datapath around one shared fixed-point multiplier
module mpc_iter import mpc_pkg::*; #(
    parameter int MAX_ITERATIONS = DEF_MAX_ITERATIONS,
    parameter int FRACTION_BITS  = DEF_FRACTION_BITS,
    localparam int NW            = $clog2(MAX_ITERATIONS + 1)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  it_op_t                   op,
    input  logic [FRACTION_BITS+4:0] quo,
    output iter_status_t             status,
    output logic [NW-1:0]            count
);

    localparam int W = FRACTION_BITS + 4;
    localparam int M = FRACTION_BITS + 3;

    localparam logic [W+1:0] LIM          = {3'b000, {M{1'b1}}};
    localparam logic [W+1:0] EIGHT_THIRDS = (W+2)'((64'd8 << FRACTION_BITS) / 64'd3);
    localparam logic [W+1:0] TWO          = (W+2)'(2) << FRACTION_BITS;
    localparam logic [W:0]   FOUR         = (W+1)'(4) << FRACTION_BITS;

    // sign extension by two bits
    function automatic logic [W+1:0] sx(input logic [W-1:0] v);
        return {{2{v[W-1]}}, v};
    endfunction

    // saturate to the symmetric fixed-point range
    function automatic logic [W-1:0] sat(input logic [W+1:0] v);
        logic signed [W+1:0] s;
        logic signed [W+1:0] lim_s;
        logic signed [W+1:0] nlim_s;
        s      = $signed(v);
        lim_s  = $signed(LIM);
        nlim_s = -lim_s;
        if (s > lim_s)
            return LIM[W-1:0];
        else if (s < nlim_s)
            return nlim_s[W-1:0];
        else
            return v[W-1:0];
    endfunction

    logic [W-1:0]  zr_reg, zr_next;
    logic [W-1:0]  zi_reg, zi_next;
    logic [W-1:0]  cr_reg, cr_next;
    logic [W-1:0]  ci_reg, ci_next;
    logic [W-1:0]  sr_reg, sr_next;
    logic [W-1:0]  si_reg, si_next;
    logic [W-1:0]  p_reg, p_next;
    logic [NW-1:0] n_reg, n_next;

    logic [W-1:0]   mul_a, mul_b;
    logic [W-1:0]   a_neg, b_neg;
    logic [M-1:0]   a_mag, b_mag;
    logic [2*M-1:0] prod;
    logic [W+1:0]   prod_sh;
    logic [M-1:0]   prod_mag;
    logic [W-1:0]   mul_res;
    logic           mul_sign;

    // operand select for the shared multiplier
    always_comb
    begin
        case (op)
            IT_SQR_R:
            begin
                mul_a = zr_reg;
                mul_b = zr_reg;
            end
            IT_SQR_I:
            begin
                mul_a = zi_reg;
                mul_b = zi_reg;
            end
            default:
            begin
                mul_a = zr_reg;
                mul_b = zi_reg;
            end
        endcase
    end

    // sign-magnitude multiply, truncated toward zero and saturated
    always_comb
    begin
        a_neg    = ~mul_a + 1'b1;
        b_neg    = ~mul_b + 1'b1;
        a_mag    = mul_a[W-1] ? a_neg[M-1:0] : mul_a[M-1:0];
        b_mag    = mul_b[W-1] ? b_neg[M-1:0] : mul_b[M-1:0];
        mul_sign = mul_a[W-1] ^ mul_b[W-1];
        prod     = {{M{1'b0}}, a_mag} * {{M{1'b0}}, b_mag};
        prod_sh  = prod[2*M-1:FRACTION_BITS];
        prod_mag = (prod_sh > LIM) ? LIM[M-1:0] : prod_sh[M-1:0];
        mul_res  = mul_sign ? (~{1'b0, prod_mag} + 1'b1) : {1'b0, prod_mag};
    end

    // register updates per operation
    always_comb
    begin
        zr_next = zr_reg;
        zi_next = zi_reg;
        cr_next = cr_reg;
        ci_next = ci_reg;
        sr_next = sr_reg;
        si_next = si_reg;
        p_next  = p_reg;
        n_next  = n_reg;
        case (op)
            IT_LOAD_CR:
                cr_next = sat({1'b0, quo} - EIGHT_THIRDS);
            IT_LOAD_CI:
            begin
                ci_next = sat({1'b0, quo} - TWO);
                zr_next = '0;
                zi_next = '0;
                n_next  = '0;
            end
            IT_SQR_R:
                sr_next = mul_res;
            IT_SQR_I:
                si_next = mul_res;
            IT_CROSS:
                p_next = mul_res;
            IT_UPDATE:
            begin
                zr_next = sat(sx(sat(sx(sr_reg) - sx(si_reg))) + sx(cr_reg));
                zi_next = sat(sx(sat({p_reg[W-1], p_reg, 1'b0})) + sx(ci_reg));
                n_next  = n_reg + 1'b1;
            end
            default:
            begin
                n_next = n_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zr_reg <= '0;
            zi_reg <= '0;
            cr_reg <= '0;
            ci_reg <= '0;
            sr_reg <= '0;
            si_reg <= '0;
            p_reg  <= '0;
            n_reg  <= '0;
        end
        else
        begin
            zr_reg <= zr_next;
            zi_reg <= zi_next;
            cr_reg <= cr_next;
            ci_reg <= ci_next;
            sr_reg <= sr_next;
            si_reg <= si_next;
            p_reg  <= p_next;
            n_reg  <= n_next;
        end
    end

    // escape test on the stored squares, limit test on the count
    assign status.escape   = (({1'b0, sr_reg} + {1'b0, si_reg}) > FOUR);
    assign status.at_limit = (n_reg == NW'(MAX_ITERATIONS - 1));
    assign count           = n_reg;

endmodule

/* rtl/core/mpc_color.sv */
// count scaling by a reciprocal multiply, then the color fifths
module mpc_color import mpc_pkg::*; #(
    parameter int MAX_ITERATIONS = DEF_MAX_ITERATIONS,
    localparam int NW            = $clog2(MAX_ITERATIONS + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [NW-1:0]      count,
    output logic               valid,
    output logic [COLOR_W-1:0] red,
    output logic [COLOR_W-1:0] green,
    output logic [COLOR_W-1:0] blue,
    output logic [COLOR_W-1:0] iteration_count
);

    // count*255 fits NUMW bits; the rounded-up reciprocal is exact over that range
    localparam int NUMW = NW + 8;
    localparam int SH   = NUMW + $clog2(MAX_ITERATIONS);
    localparam int RW   = NUMW + 1;
    localparam logic [RW-1:0] RECIP_MAX =
        RW'(((64'd1 << SH) + 64'(MAX_ITERATIONS) - 64'd1) / 64'(MAX_ITERATIONS));
    localparam logic [15:0]     RECIP5  = 16'd52429;

    typedef enum logic [1:0] {
        C_IDLE,
        C_DIV,
        C_OUT
    } color_state_t;

    color_state_t        state_reg, state_next;
    logic [NUMW-1:0]     rem_reg, rem_next;
    logic [7:0]          val_reg, val_next;
    logic [NW-1:0]       n_reg, n_next;
    logic                valid_reg, valid_next;
    logic [COLOR_W-1:0]  red_reg, red_next;
    logic [COLOR_W-1:0]  green_reg, green_next;
    logic [COLOR_W-1:0]  blue_reg, blue_next;

    logic [NUMW+RW-1:0]  scaled;
    logic [24:0]         red_prod;
    logic [25:0]         green_prod;

    // count*255 over MAX_ITERATIONS as a reciprocal multiply
    always_comb
    begin
        scaled = {{RW{1'b0}}, rem_reg} * {{NUMW{1'b0}}, RECIP_MAX};
    end

    // division by five as a reciprocal multiply, exact for these ranges
    always_comb
    begin
        red_prod   = {16'd0, val_reg, 1'b0} * {9'd0, RECIP5};
        green_prod = {16'd0, val_reg, 2'b00} * {10'd0, RECIP5};
    end

    // sequencer for count*255/MAX_ITERATIONS and the color outputs
    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        val_next   = val_reg;
        n_next     = n_reg;
        valid_next = 1'b0;
        red_next   = red_reg;
        green_next = green_reg;
        blue_next  = blue_reg;
        case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    n_next     = count;
                    rem_next   = {count, 8'd0} - {8'd0, count};
                    state_next = C_DIV;
                end
            end
            C_DIV:
            begin
                val_next   = scaled[SH+7:SH];
                state_next = C_OUT;
            end
            C_OUT:
            begin
                red_next   = {1'b0, red_prod[24:18]};
                green_next = green_prod[25:18];
                blue_next  = val_reg;
                valid_next = 1'b1;
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            rem_reg   <= '0;
            val_reg   <= '0;
            n_reg     <= '0;
            valid_reg <= 1'b0;
            red_reg   <= '0;
            green_reg <= '0;
            blue_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rem_reg   <= rem_next;
            val_reg   <= val_next;
            n_reg     <= n_next;
            valid_reg <= valid_next;
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign valid           = valid_reg;
    assign red             = red_reg;
    assign green           = green_reg;
    assign blue            = blue_reg;
    assign iteration_count = COLOR_W'(n_reg);

endmodule

/* rtl/core/mandelbrot_pixel_colorizer_core.sv */
// Mandelbrot escape-time pixel colorizer: a pixel goes in on start while busy is
// low, and its color comes back as a one-cycle result_valid strobe with red,
// green, blue and iteration_count; the receiver cannot stall, so take the result
// in that cycle. One pixel is worked at a time and busy stays high until its
// strobe. A pixel stops iterating when it escapes or when its count reaches
// MAX_ITERATIONS. The two coordinate divisions run one quotient bit per cycle
// on a shared divider, each quotient then handed over to the iteration unit;
// each iteration steps through zr squared, zi squared and the cross product on
// the single shared multiplier, then the update. The escape test on the stored
// squares is made in the cross-product step, and an escaping pixel skips the
// update and goes on to the color stage. busy falls the cycle after the strobe,
// so the next pixel can be taken at the end of that cycle at the earliest.
// Width and height are written through cfg_write, cfg_index and cfg_data; the
// user must write them only while the block is idle, which the block itself
// does not enforce. A value of zero acts as one.
module mandelbrot_pixel_colorizer_core import mpc_pkg::*; #(
    parameter int MAX_ITERATIONS = DEF_MAX_ITERATIONS,
    parameter int FRACTION_BITS  = DEF_FRACTION_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [COORD_W-1:0]   pixel_x,
    input  logic [COORD_W-1:0]   pixel_y,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output logic                 result_valid,
    output logic [COLOR_W-1:0]   red,
    output logic [COLOR_W-1:0]   green,
    output logic [COLOR_W-1:0]   blue,
    output logic [COLOR_W-1:0]   iteration_count
);

    localparam int NW = $clog2(MAX_ITERATIONS + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIVX,
        S_DIVY,
        S_SQR_R,
        S_SQR_I,
        S_CROSS,
        S_UPD,
        S_COLOR_GO,
        S_COLOR_WAIT
    } seq_state_t;

    seq_state_t           state_reg, state_next;
    logic [CFG_W-1:0]     width_reg, width_next;
    logic [CFG_W-1:0]     height_reg, height_next;
    logic [COORD_W-1:0]   py_reg, py_next;

    logic [CFG_W-1:0]         width_eff, height_eff;
    logic                     div_start;
    logic [COORD_W+1:0]       div_num;
    logic [CFG_W-1:0]         div_den;
    logic                     div_done;
    logic [FRACTION_BITS+4:0] div_quo;
    it_op_t                   it_op;
    iter_status_t             it_status;
    logic [NW-1:0]            it_count;
    logic                     color_start;
    logic                     color_valid;

    // zero size acts as one
    assign width_eff  = (width_reg == '0) ? CFG_W'(1) : width_reg;
    assign height_eff = (height_reg == '0) ? CFG_W'(1) : height_reg;

    // configuration registers
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_IDX_WIDTH:  width_next  = cfg_data;
                CFG_IDX_HEIGHT: height_next = cfg_data;
                default:        width_next  = width_reg;
            endcase
        end
    end

    // pixel sequencer
    always_comb
    begin
        state_next  = state_reg;
        py_next     = py_reg;
        div_start   = 1'b0;
        div_num     = {pixel_x, 2'b00};
        div_den     = width_eff;
        it_op       = IT_NOP;
        color_start = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    div_start  = 1'b1;
                    py_next    = pixel_y;
                    state_next = S_DIVX;
                end
            end
            S_DIVX:
            begin
                if (div_done)
                begin
                    it_op      = IT_LOAD_CR;
                    div_start  = 1'b1;
                    div_num    = {py_reg, 2'b00};
                    div_den    = height_eff;
                    state_next = S_DIVY;
                end
            end
            S_DIVY:
            begin
                if (div_done)
                begin
                    it_op      = IT_LOAD_CI;
                    state_next = S_SQR_R;
                end
            end
            S_SQR_R:
            begin
                it_op      = IT_SQR_R;
                state_next = S_SQR_I;
            end
            S_SQR_I:
            begin
                it_op      = IT_SQR_I;
                state_next = S_CROSS;
            end
            S_CROSS:
            begin
                it_op      = IT_CROSS;
                state_next = it_status.escape ? S_COLOR_GO : S_UPD;
            end
            S_UPD:
            begin
                it_op      = IT_UPDATE;
                state_next = it_status.at_limit ? S_COLOR_GO : S_SQR_R;
            end
            S_COLOR_GO:
            begin
                color_start = 1'b1;
                state_next  = S_COLOR_WAIT;
            end
            S_COLOR_WAIT:
            begin
                if (color_valid)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            py_reg     <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            py_reg     <= py_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    // coordinate divider, shared by both axes
    mpc_div #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // iteration datapath
    mpc_iter #(
        .MAX_ITERATIONS (MAX_ITERATIONS),
        .FRACTION_BITS  (FRACTION_BITS)
    ) u_iter (
        .clk    (clk),
        .rst_n  (rst_n),
        .op     (it_op),
        .quo    (div_quo),
        .status (it_status),
        .count  (it_count)
    );

    // color mapping and result registers
    mpc_color #(
        .MAX_ITERATIONS (MAX_ITERATIONS)
    ) u_color (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (color_start),
        .count           (it_count),
        .valid           (color_valid),
        .red             (red),
        .green           (green),
        .blue            (blue),
        .iteration_count (iteration_count)
    );

    assign result_valid = color_valid;

endmodule
